/* rtl/core/mcm_pkg.sv */
// shared types, constants and lookup tables for the marching cubes cell mesher
package mcm_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 12;

   localparam int CUBE_FIELD_W = 10;
   localparam int DENS_W       = 16;
   localparam int COORD_W      = 32;
   localparam int STEP_W       = 31;
   localparam int REQ_W        = 160;
   localparam int RSP_W        = 128;
   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;

   localparam int CUBE_BITS = (COORD_BITS < CUBE_FIELD_W) ? COORD_BITS : CUBE_FIELD_W;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int MAG_W     = DENS_W;
   localparam int NUM_W     = DENS_W + 1 + FRAC_BITS;
   localparam int CNT_W     = $clog2(FRAC_BITS + 1);
   localparam int P_W       = CUBE_BITS + FRAC_BITS + 1;
   localparam int PROD_W    = P_W + STEP_W;
   localparam int OFF_W     = PROD_W + 1 - FRAC_BITS;
   localparam int SUM_W     = ((OFF_W > COORD_W) ? OFF_W : COORD_W) + 2;

   localparam logic [T_W-1:0] T_ONE  = T_W'(1) << FRAC_BITS;
   localparam logic [T_W-1:0] T_HALF = T_W'(1) << (FRAC_BITS - 1);

   localparam int TRI_CHARS = 15;
   localparam int TRI_W     = 8 * TRI_CHARS;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [3:0] EDGE_LAST  = 4'd11;

   typedef enum logic [2:0] {
      REG_ISO_LEVEL,
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_ORIGIN_Z,
      REG_STEP_X,
      REG_STEP_Y,
      REG_STEP_Z
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EDGE,
      ST_DIV,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [DENS_W-1:0]  iso_level;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [STEP_W-1:0]         step_x;
      logic [STEP_W-1:0]         step_y;
      logic [STEP_W-1:0]         step_z;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [MAG_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [T_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic [P_W-1:0]            pos;
      logic [STEP_W-1:0]         step;
      logic signed [COORD_W-1:0] origin;
   } world_req_type;

   function automatic logic [3:0] hex_edge(input logic [7:0] ch);
      logic [3:0] e;
      e = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         e = 4'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_F) begin
         e = 4'(ch - CHAR_LOW_A + 8'd10);
      end
      if (e > EDGE_LAST) begin
         e = '0;
      end
      return e;
   endfunction

   function automatic logic [2:0] edge_corner_a(input logic [3:0] e);
      logic [2:0] c;
      unique case (e)
         4'd0:    c = 3'd0;
         4'd1:    c = 3'd1;
         4'd2:    c = 3'd2;
         4'd3:    c = 3'd3;
         4'd4:    c = 3'd4;
         4'd5:    c = 3'd5;
         4'd6:    c = 3'd6;
         4'd7:    c = 3'd7;
         4'd8:    c = 3'd0;
         4'd9:    c = 3'd1;
         4'd10:   c = 3'd2;
         4'd11:   c = 3'd3;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] edge_corner_b(input logic [3:0] e);
      logic [2:0] c;
      unique case (e)
         4'd0:    c = 3'd1;
         4'd1:    c = 3'd2;
         4'd2:    c = 3'd3;
         4'd3:    c = 3'd0;
         4'd4:    c = 3'd5;
         4'd5:    c = 3'd6;
         4'd6:    c = 3'd7;
         4'd7:    c = 3'd4;
         4'd8:    c = 3'd4;
         4'd9:    c = 3'd5;
         4'd10:   c = 3'd6;
         4'd11:   c = 3'd7;
         default: c = 3'd1;
      endcase
      return c;
   endfunction

   function automatic logic corner_bit(input logic [2:0] c, input axis_type axis);
      logic b;
      unique case (axis)
         AXIS_X:  b = (c == 3'd1) || (c == 3'd2) || (c == 3'd5) || (c == 3'd6);
         AXIS_Y:  b = (c == 3'd2) || (c == 3'd3) || (c == 3'd6) || (c == 3'd7);
         AXIS_Z:  b = c[2];
         default: b = 1'b0;
      endcase
      return b;
   endfunction

   // edge lists, first edge in the highest used byte
   localparam logic [TRI_W-1:0] TRI_LIST [256] = '{
      "","083","019","183981","12a","08312a","92a029","2832a8a98",
      "3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
      "478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
      "8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4",
      "47890b9bab03","47b4b99ba",
      "954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
      "95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba",
      "54050b5bab03","54858aa8b",
      "978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
      "2a5253357",
      "7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b",
      "5705097b010aba0","ba0b03a50807570","ba57b5",
      "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
      "23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6",
      "3b6036065059","65969bb98",
      "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347",
      "847905065026","739794329596269",
      "3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
      "51b5b610b7b404b","059065036b63847","65969b4797b9",
      "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
      "832824426",
      "a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
      "8b1810b61914641","3b6360064","648b68",
      "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867",
      "269291679093739","780706602","732672",
      "23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
      "091b67","7807063b0b60","7b6",
      "76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
      "723627","708760620","276237019","162186198876","a76a17137","a7617a187108",
      "03707a0a96a7","76a7a88a9",
      "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046",
      "4b846b0292a9","a93a32943b36463",
      "823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
      "4634386a3039a93","a946a4",
      "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495",
      "76b54a42a402","348354325a52b76",
      "723762549","954086062687","362376150540","628687218485158","954a16176137",
      "16a176107870954","40a4a503a6a737a","76a7a854a48a",
      "6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56",
      "0b306b09656912a","b85b56805a52025","6b36352a3a53",
      "589528562382","956960062","158180568382628","156216","13616a386569896",
      "a10a06950560","03856a","a56",
      "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b17751","08312717572b",
      "9759279022b7","75272b592328982",
      "25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
      "903935537","987597",
      "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
      "04b0b345b2b151b","0250592b5458b85","9452b3",
      "25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
      "845853905035","945",
      "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
      "9749b791b2b1083","b74b42240","b74b42834324",
      "29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713",
      "491417081871","403743","487",
      "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
      "23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
   };

endpackage

/* rtl/core/mcm_csr.sv */
// configuration register file behind the register port
module mcm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mcm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [mcm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [mcm_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output mcm_pkg::cfg_type           cfg
);
   import mcm_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type sel;
   logic          wr;

   assign sel        = csr_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (sel)
            REG_ISO_LEVEL: cfg_in.iso_level = csr_pwdata[DENS_W-1:0];
            REG_ORIGIN_X:  cfg_in.origin_x  = csr_pwdata;
            REG_ORIGIN_Y:  cfg_in.origin_y  = csr_pwdata;
            REG_ORIGIN_Z:  cfg_in.origin_z  = csr_pwdata;
            REG_STEP_X:    cfg_in.step_x    = csr_pwdata[STEP_W-1:0];
            REG_STEP_Y:    cfg_in.step_y    = csr_pwdata[STEP_W-1:0];
            REG_STEP_Z:    cfg_in.step_z    = csr_pwdata[STEP_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_ISO_LEVEL: csr_prdata = DATA_W'(cfg_ff.iso_level);
         REG_ORIGIN_X:  csr_prdata = cfg_ff.origin_x;
         REG_ORIGIN_Y:  csr_prdata = cfg_ff.origin_y;
         REG_ORIGIN_Z:  csr_prdata = cfg_ff.origin_z;
         REG_STEP_X:    csr_prdata = DATA_W'(cfg_ff.step_x);
         REG_STEP_Y:    csr_prdata = DATA_W'(cfg_ff.step_y);
         REG_STEP_Z:    csr_prdata = DATA_W'(cfg_ff.step_z);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iso_level <= '0;
         cfg_ff.origin_x  <= '0;
         cfg_ff.origin_y  <= '0;
         cfg_ff.origin_z  <= '0;
         cfg_ff.step_x    <= STEP_W'(65536);
         cfg_ff.step_y    <= STEP_W'(65536);
         cfg_ff.step_z    <= STEP_W'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/mcm_div.sv */
// shared restoring divider for the edge fraction, one quotient bit per cycle
module mcm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mcm_pkg::div_req_type div_req,
   output mcm_pkg::div_rsp_type div_rsp
);
   import mcm_pkg::*;

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [T_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             chk_ff, chk_in;
   logic             done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      chk_in  = chk_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         dsh_in  = NUM_W'(div_req.den) << FRAC_BITS;
         q_in    = '0;
         cnt_in  = CNT_W'(FRAC_BITS);
         busy_in = 1'b1;
         chk_in  = 1'b1;
      end else if (busy_ff && chk_ff) begin
         chk_in = 1'b0;
         // quotient at or above twice one saturates directly
         if (rem_ff >= (dsh_ff << 1)) begin
            q_in    = T_ONE;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in      = rem_ff - dsh_ff;
            q_in[cnt_ff] = 1'b1;
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = (q_ff > T_ONE) ? T_ONE : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         chk_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         chk_ff  <= chk_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* rtl/core/mcm_world.sv */
// two stage scale, round, offset and saturate unit for one axis coordinate
module mcm_world (
   input  logic                                clock,
   input  mcm_pkg::world_req_type              world_req,
   output logic signed [mcm_pkg::COORD_W-1:0]  coord
);
   import mcm_pkg::*;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7fffffff);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(32'sh80000000);

   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [COORD_W-1:0] org_ff;
   logic signed [COORD_W-1:0] coord_ff, coord_in;
   logic [PROD_W:0]           rounded;
   logic [OFF_W-1:0]          off;
   logic signed [SUM_W-1:0]   sum;

   assign prod_in = PROD_W'(world_req.pos) * PROD_W'(world_req.step);
   assign rounded = (PROD_W + 1)'(prod_ff) + ROUND_HALF;
   assign off     = OFF_W'(rounded >> FRAC_BITS);
   assign sum     = SUM_W'(org_ff) + $signed(SUM_W'(off));

   always_comb begin
      if (sum > SAT_MAX) begin
         coord_in = COORD_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         coord_in = COORD_W'(SAT_MIN);
      end else begin
         coord_in = COORD_W'(sum);
      end
   end

   assign coord = coord_ff;

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      org_ff   <= world_req.origin;
      coord_ff <= coord_in;
   end

endmodule

/* rtl/core/marching_cubes_cell_mesher.sv */
// top level: cube sequencer around the shared divider and coordinate unit
//
// channel  | direction | handshake           | payload
// req      | in        | req_tvalid/tready   | cube coordinates and eight corner samples
// rsp      | out       | rsp_tvalid/tready   | vertex position and number, tlast on cube end
// csr      | in/out    | psel/penable/pready | seven configuration registers
//
// a cube is accepted while idle and its edge list is looked up in the load state;
// each vertex then passes the edge state, the one-bit-per-cycle divider (left early
// when the fraction saturates at the first compare, skipped when the edge's two
// samples are equal), the three coordinate passes and the output state, which waits out any rsp stall
// req_tready is high only while idle; empty cubes return to idle from the load state
// synchronous reset clears the sequencer and the vertex number
module marching_cubes_cell_mesher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // cube_x, cube_y, cube_z, density_c0 .. density_c7, zero fill
   input  logic [mcm_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // vert_x, vert_y, vert_z, vertex_number
   output logic [mcm_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [mcm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [mcm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [mcm_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import mcm_pkg::*;

   cfg_type       cfg;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   world_req_type world_req;
   logic signed [COORD_W-1:0] coord;
   logic          div_start;

   state_type                 state_ff, state_in;
   logic [CUBE_BITS-1:0]      cube_ff [3];
   logic [CUBE_BITS-1:0]      cube_in [3];
   logic signed [DENS_W-1:0]  dens_ff [8];
   logic signed [DENS_W-1:0]  dens_in [8];
   logic [7:0]                idx_ff, idx_in;
   logic [TRI_CHARS-1:0][7:0] list_ff, list_in;
   logic [3:0]                pos_ff, pos_in;
   logic [2:0]                ca_ff, ca_in, cb_ff, cb_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic [2:0]                m_ff, m_in;
   logic signed [COORD_W-1:0] vert_ff [3];
   logic signed [COORD_W-1:0] vert_in [3];
   logic [COORD_W-1:0]        count_ff, count_in;

   logic [TRI_W-1:0]          entry;
   logic [3:0]                len;
   logic [3:0]                edge_num;
   logic [2:0]                ea, eb;
   logic signed [DENS_W:0]    dn, dd;
   logic [MAG_W-1:0]          mag_dn, mag_dd;
   axis_type                  axis;
   logic                      oa, ob;
   logic [P_W-1:0]            base;
   logic [1:0]                vsel;

   mcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mcm_world u_world (
      .clock     (clock),
      .world_req (world_req),
      .coord     (coord)
   );

   // edge list lookup and length
   always_comb begin
      entry = TRI_LIST[idx_ff];
      len   = '0;
      for (int k = 0; k < TRI_CHARS; k++) begin
         if (entry[8*k +: 8] != '0) begin
            len = len + 4'd1;
         end
      end
   end

   // current edge and its fraction operands
   always_comb begin
      edge_num = hex_edge(list_ff[pos_ff]);
      ea       = edge_corner_a(edge_num);
      eb       = edge_corner_b(edge_num);
      dn       = (DENS_W + 1)'(cfg.iso_level) - (DENS_W + 1)'(dens_ff[ea]);
      dd       = (DENS_W + 1)'(dens_ff[eb]) - (DENS_W + 1)'(dens_ff[ea]);
      mag_dn   = dn[DENS_W] ? MAG_W'(-dn) : MAG_W'(dn);
      mag_dd   = dd[DENS_W] ? MAG_W'(-dd) : MAG_W'(dd);
   end

   assign div_req = '{start: div_start,
                      num:   (NUM_W'(mag_dn) << FRAC_BITS) + NUM_W'(mag_dd >> 1),
                      den:   mag_dd};

   // axis operand for the coordinate unit
   always_comb begin
      axis = (m_ff > 3'd2) ? AXIS_Z : axis_type'(m_ff[1:0]);
      oa   = corner_bit(ca_ff, axis);
      ob   = corner_bit(cb_ff, axis);
      base = (P_W'(cube_ff[axis]) + P_W'(oa)) << FRAC_BITS;
      if (ob && !oa) begin
         world_req.pos = base + P_W'(t_ff);
      end else if (oa && !ob) begin
         world_req.pos = base - P_W'(t_ff);
      end else begin
         world_req.pos = base;
      end
      unique case (axis)
         AXIS_X: begin
            world_req.step   = cfg.step_x;
            world_req.origin = cfg.origin_x;
         end
         AXIS_Y: begin
            world_req.step   = cfg.step_y;
            world_req.origin = cfg.origin_y;
         end
         default: begin
            world_req.step   = cfg.step_z;
            world_req.origin = cfg.origin_z;
         end
      endcase
   end

   assign vsel = 2'(m_ff - 3'd2);

   always_comb begin
      state_in      = state_ff;
      cube_in       = cube_ff;
      dens_in       = dens_ff;
      idx_in        = idx_ff;
      list_in       = list_ff;
      pos_in        = pos_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      t_in          = t_ff;
      m_in          = m_ff;
      vert_in       = vert_ff;
      count_in      = count_ff;
      div_start     = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int a = 0; a < 3; a++) begin
                  cube_in[a] = req_tdata[CUBE_FIELD_W*a +: CUBE_BITS];
               end
               for (int c = 0; c < 8; c++) begin
                  dens_in[c] = req_tdata[3*CUBE_FIELD_W + DENS_W*c +: DENS_W];
                  idx_in[c]  = $signed(req_tdata[3*CUBE_FIELD_W + DENS_W*c +: DENS_W])
                               < cfg.iso_level;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            list_in = entry;
            pos_in  = len - 4'd1;
            state_in = (len == '0) ? ST_IDLE : ST_EDGE;
         end
         ST_EDGE: begin
            ca_in = ea;
            cb_in = eb;
            m_in  = '0;
            if (dd == '0) begin
               t_in     = T_HALF;
               state_in = ST_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            m_in = '0;
            if (div_rsp.done) begin
               t_in     = div_rsp.quot;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            m_in = m_ff + 3'd1;
            if (m_ff >= 3'd2) begin
               vert_in[vsel] = coord;
            end
            if (m_ff == 3'd4) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               count_in = count_ff + COORD_W'(1);
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff - 4'd1;
                  state_in = ST_EDGE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tdata = {count_ff, vert_ff[2], vert_ff[1], vert_ff[0]};
   assign rsp_tlast = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cube_ff <= cube_in;
      dens_ff <= dens_in;
      idx_ff  <= idx_in;
      list_ff <= list_in;
      pos_ff  <= pos_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      t_ff    <= t_in;
      m_ff    <= m_in;
      vert_ff <= vert_in;
   end

endmodule

/* tb/tb.sv */
// self-checking testbench for the marching cubes cell mesher
`timescale 1ns / 100ps

module tb;
   import mcm_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int SETTLE       = 60;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] num;
      logic        last;
   } vertex_type;

   typedef struct {
      logic [REQ_W-1:0] tdata;
      int               verts;
   } cube_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                rsp_tlast;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   vertex_type  verts_due[$];
   int          fail_count = 0;
   int          cubes_sent = 0;
   int          verts_seen = 0;
   int          cycle_count = 0;
   bit          squeeze = 1'b0;

   // mirrored configuration and vertex number
   int          iso_q = 0;
   longint      origin_q[3] = '{0, 0, 0};
   longint      step_q[3] = '{65536, 65536, 65536};
   logic [31:0] vert_num_q = '0;

   int edge_a[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
   int edge_b[12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

   marching_cubes_cell_mesher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic int corner_axis(input int c, input int axis);
      case (axis)
         0:       return (c == 1 || c == 2 || c == 5 || c == 6) ? 1 : 0;
         1:       return (c == 2 || c == 3 || c == 6 || c == 7) ? 1 : 0;
         default: return (c >= 4) ? 1 : 0;
      endcase
   endfunction

   function automatic longint edge_frac(input int va, input int vb);
      longint dn;
      longint dd;
      longint t;
      if (va == vb) return longint'(1) << (FRAC_BITS - 1);
      dn = longint'(iso_q) - va;
      dd = longint'(vb) - va;
      if (dn < 0) dn = -dn;
      if (dd < 0) dd = -dd;
      t = ((dn << FRAC_BITS) + (dd >> 1)) / dd;
      if (t > (longint'(1) << FRAC_BITS)) t = longint'(1) << FRAC_BITS;
      return t;
   endfunction

   function automatic logic [31:0] world_coord(input int axis, input longint cube,
                                               input int ca, input int cb, input longint t);
      longint p;
      longint s;
      int     oa;
      int     ob;
      oa = corner_axis(ca, axis);
      ob = corner_axis(cb, axis);
      p = (cube + oa) << FRAC_BITS;
      if (ob > oa) p = p + t;
      else if (ob < oa) p = p - t;
      s = origin_q[axis] + ((p * step_q[axis] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
      if (s < -64'sh80000000) s = -64'sh80000000;
      return s[31:0];
   endfunction

   function automatic void predict_vertices(input logic [REQ_W-1:0] d);
      int                 dens[8];
      longint             cube[3];
      logic signed [15:0] s;
      logic [7:0]         idx;
      logic [TRI_W-1:0]   lst;
      logic [7:0]         ch;
      int                 e;
      int                 n;
      longint             t;
      vertex_type         v;
      idx = '0;
      n = 0;
      for (int a = 0; a < 3; a++) cube[a] = longint'(d[10*a +: COORD_BITS]);
      for (int c = 0; c < 8; c++) begin
         s = d[30 + 16*c +: 16];
         dens[c] = s;
         if (dens[c] < iso_q) idx[c] = 1'b1;
      end
      lst = TRI_LIST[idx];
      for (int k = TRI_CHARS - 1; k >= 0; k--) begin
         ch = lst[8*k +: 8];
         if (ch == 8'h00) continue;
         if (ch >= "0" && ch <= "9") e = ch - "0";
         else if (ch >= "a" && ch <= "f") e = ch - "a" + 10;
         else e = 0;
         if (e > 11) e = 0;
         t = edge_frac(dens[edge_a[e]], dens[edge_b[e]]);
         v.x = world_coord(0, cube[0], edge_a[e], edge_b[e], t);
         v.y = world_coord(1, cube[1], edge_a[e], edge_b[e], t);
         v.z = world_coord(2, cube[2], edge_a[e], edge_b[e], t);
         v.num = vert_num_q;
         v.last = 1'b0;
         vert_num_q = vert_num_q + 1;
         verts_due.push_back(v);
         n++;
      end
      if (n > 0) verts_due[verts_due.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [REQ_W-1:0] pack_cube(input logic [9:0] cx, input logic [9:0] cy,
                                                  input logic [9:0] cz,
                                                  input logic [15:0] dens [8]);
      logic [REQ_W-1:0] d;
      d = '0;
      d[9:0] = cx;
      d[19:10] = cy;
      d[29:20] = cz;
      for (int c = 0; c < 8; c++) d[30 + 16*c +: 16] = dens[c];
      return d;
   endfunction

   // request, result and register write monitor
   always @(posedge clock) begin
      vertex_type exp_v;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_ISO_LEVEL: iso_q = $signed(csr_pwdata[15:0]);
               REG_ORIGIN_X:  origin_q[0] = $signed(csr_pwdata);
               REG_ORIGIN_Y:  origin_q[1] = $signed(csr_pwdata);
               REG_ORIGIN_Z:  origin_q[2] = $signed(csr_pwdata);
               REG_STEP_X:    step_q[0] = csr_pwdata[30:0];
               REG_STEP_Y:    step_q[1] = csr_pwdata[30:0];
               REG_STEP_Z:    step_q[2] = csr_pwdata[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_vertices(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            verts_seen++;
            if (verts_due.size() == 0) begin
               $error("unexpected vertex %h", rsp_tdata);
               fail_count++;
            end else begin
               exp_v = verts_due.pop_front();
               if (rsp_tdata[31:0] !== exp_v.x) begin
                  $error("vert_x expected %h actual %h", exp_v.x, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== exp_v.y) begin
                  $error("vert_y expected %h actual %h", exp_v.y, rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tdata[95:64] !== exp_v.z) begin
                  $error("vert_z expected %h actual %h", exp_v.z, rsp_tdata[95:64]);
                  fail_count++;
               end
               if (rsp_tdata[127:96] !== exp_v.num) begin
                  $error("vertex_number expected %0d actual %0d", exp_v.num,
                         rsp_tdata[127:96]);
                  fail_count++;
               end
               if (rsp_tlast !== exp_v.last) begin
                  $error("last_of_cube expected %b actual %b", exp_v.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[marching_cubes_cell_mesher] ERROR");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int mode;
      int len;
      forever begin
         @(posedge clock);
         if (squeeze) begin
            rsp_tready <= 1'b0;
            repeat (800) @(posedge clock);
            squeeze = 1'b0;
         end else begin
            mode = $urandom_range(0, 19);
            if (mode < 12) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(1, 12);
            end else if (mode < 19) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               len = $urandom_range(10, 40);
            end
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   task automatic send_cube(input logic [REQ_W-1:0] d);
      int gap;
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      cubes_sent++;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                        : $urandom_range(0, 1) * $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verts_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [REQ_W-1:0] random_cube();
      logic [15:0] dens[8];
      int          v;
      for (int c = 0; c < 8; c++) begin
         if ($urandom_range(0, 7) == 0) begin
            dens[c] = 16'($urandom);
         end else begin
            v = iso_q + $urandom_range(0, 800) - 400;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            dens[c] = 16'(v);
         end
      end
      return pack_cube(10'($urandom), 10'($urandom), 10'($urandom), dens);
   endfunction

   initial begin
      cube_row_type rows[8];
      int           before_n;
      int           got;
      logic [31:0]  stp;
      rows[0] = '{pack_cube(0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0}), 0};
      rows[1] = '{pack_cube(10'h3FF, 10'h3FF, 10'h3FF,
                  '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000}), 0};
      rows[2] = '{pack_cube(0, 0, 0, '{16'hFFFF, 0, 0, 0, 0, 0, 0, 0}), 3};
      rows[3] = '{pack_cube(10'h3FF, 10'h3FF, 10'h3FF,
                  '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                    16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}), 3};
      // five triangles
      rows[4] = '{pack_cube(5, 9, 17, '{-100, 100, -100, -100, -100, -100, 100, 100}), 15};
      rows[5] = '{pack_cube(1, 2, 3, '{-1, 1, -1, 1, -1, 1, -1, 1}), -1};
      rows[6] = '{pack_cube(10'h2AA, 10'h155, 10'h0F0,
                  '{16'h8000, 16'h7FFF, 16'h8001, 16'h7FFE,
                    16'h0001, 16'hFFFE, 16'h1234, 16'hEDCB}), -1};
      rows[7] = '{pack_cube(7, 7, 7, '{-256, 255, 256, -255, 0, -1, 1, 16'h8000}), -1};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         before_n = verts_seen;
         send_cube(rows[i].tdata);
         wait_drained();
         got = verts_seen - before_n;
         if (rows[i].verts >= 0 && got != rows[i].verts) begin
            $error("vertex count expected %0d actual %0d", rows[i].verts, got);
            fail_count++;
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(REG_ISO_LEVEL, 32'h0000_7FFF);
               csr_write(REG_ORIGIN_X, 32'h7FFF_FFFF);
               csr_write(REG_ORIGIN_Y, 32'h8000_0000);
               csr_write(REG_ORIGIN_Z, 32'h0);
               csr_write(REG_STEP_X, 32'h7FFF_FFFF);
               csr_write(REG_STEP_Y, 32'hFFFF_FFFF);
               csr_write(REG_STEP_Z, 32'h0);
               csr_write(7, 32'hDEAD_BEEF);
            end
            1: begin
               csr_write(REG_ISO_LEVEL, 32'hFFFF_8000);
               csr_write(REG_ORIGIN_X, 32'h8000_0000);
               csr_write(REG_ORIGIN_Y, 32'h7FFF_FFFF);
               csr_write(REG_ORIGIN_Z, 32'hFFFF_FFFF);
               csr_write(REG_STEP_X, 32'h0);
               csr_write(REG_STEP_Y, 32'h0001_0000);
               csr_write(REG_STEP_Z, 32'h7FFF_FFFF);
            end
            default: begin
               csr_write(REG_ISO_LEVEL, $urandom);
               for (int a = 0; a < 3; a++) begin
                  csr_write(REG_ORIGIN_X + a, $urandom);
                  stp = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h3FFFF);
                  csr_write(REG_STEP_X + a, stp);
               end
            end
         endcase
         if (phase == 3) squeeze = 1'b1;
         for (int n = 0; n < 42; n++) send_cube(random_cube());
         wait_drained();
      end

      $display("covered %0d cubes and %0d vertices over directed and six register settings",
               cubes_sent, verts_seen);
      $display("register extremes, zero steps, saturation and a long output stall included");
      if (fail_count == 0) begin
         $display("[marching_cubes_cell_mesher] OK");
      end else begin
         $display("[marching_cubes_cell_mesher] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/mcm_pkg.sv
rtl/core/mcm_csr.sv
rtl/core/mcm_div.sv
rtl/core/mcm_world.sv
rtl/core/marching_cubes_cell_mesher.sv
tb/tb.sv
